// File: hw/rtl/des_pkg.sv
package des_pkg;

    localparam int Rounds = 16;
    localparam int RegKey = 0;
    localparam int RegMode = 1;

    typedef logic [63:0] block_t;
    typedef logic [47:0] subkey_t;
    typedef logic [55:0] cd_t;

    // Write index of the configuration channel.
    typedef logic [0:0] cfg_idx_t;

    typedef logic [6:0] pos_t;

    localparam pos_t TabIp [64] = '{
        58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
    localparam pos_t TabFp [64] = '{
        40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
    localparam pos_t TabE [48] = '{
        32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
        16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
    localparam pos_t TabP [32] = '{
        16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
    localparam pos_t TabPc1 [56] = '{
        57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
        60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
        29,21,13,5,28,20,12,4};
    localparam pos_t TabPc2 [48] = '{
        14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
        41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
    localparam logic [1:0] TabRot [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
    localparam logic [3:0] TabSbox [8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    function automatic block_t perm_ip(input block_t v);
        block_t r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64 - int'(TabIp[i])];
        return r;
    endfunction

    function automatic block_t perm_fp(input block_t v);
        block_t r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64 - int'(TabFp[i])];
        return r;
    endfunction

    function automatic cd_t perm_pc1(input block_t v);
        cd_t r;
        for (int i = 0; i < 56; i++) r[55-i] = v[64 - int'(TabPc1[i])];
        return r;
    endfunction

    function automatic subkey_t perm_pc2(input cd_t v);
        subkey_t r;
        for (int i = 0; i < 48; i++) r[47-i] = v[56 - int'(TabPc2[i])];
        return r;
    endfunction

    function automatic logic [27:0] rot28(input logic [27:0] h, input logic [1:0] s);
        return (s == 2'd1) ? {h[26:0], h[27]} : {h[25:0], h[27:26]};
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input subkey_t k);
        logic [47:0] x;
        logic [5:0]  six;
        logic [31:0] s;
        logic [31:0] p;
        for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(TabE[i])];
        x = x ^ k;
        for (int g = 0; g < 8; g++)
        begin
            six = x[47-6*g -: 6];
            s[31-4*g -: 4] = TabSbox[g][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32 - int'(TabP[i])];
        return p;
    endfunction

endpackage

// File: hw/rtl/des_stream_if.sv
interface des_stream_if;
    logic               valid;
    logic               ready;
    des_pkg::block_t    data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/des_cfg_if.sv
interface des_cfg_if;
    logic              valid;
    logic              ready;
    des_pkg::cfg_idx_t index;
    des_pkg::block_t   wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: hw/rtl/des_keysched.sv
module des_keysched (
    input  logic            clk,
    input  logic            rst_n,
    des_cfg_if.sink         cfg,
    output des_pkg::subkey_t round_key [des_pkg::Rounds]
);
    des_pkg::block_t key_reg;
    logic            decrypt_reg;
    logic [55:0]     cd_stage [des_pkg::Rounds];
    des_pkg::subkey_t ks [des_pkg::Rounds];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg     <= '0;
            decrypt_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                1'(des_pkg::RegKey):  key_reg <= cfg.wdata;
                1'(des_pkg::RegMode): decrypt_reg <= cfg.wdata[0];
                default: ;
            endcase
        end
    end

    // Subkeys are wired from held key; user changes it only while idle, unchecked.
    always_comb
    begin
        logic [27:0] c;
        logic [27:0] d;
        logic [55:0] cd;
        cd = des_pkg::perm_pc1(key_reg);
        c = cd[55:28];
        d = cd[27:0];
        for (int i = 0; i < des_pkg::Rounds; i++)
        begin
            c = des_pkg::rot28(c, des_pkg::TabRot[i]);
            d = des_pkg::rot28(d, des_pkg::TabRot[i]);
            cd_stage[i] = {c, d};
            ks[i] = des_pkg::perm_pc2(cd_stage[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < des_pkg::Rounds; i++)
            round_key[i] = decrypt_reg ? ks[des_pkg::Rounds-1-i] : ks[i];
    end
endmodule

// File: hw/rtl/des_round.sv
module des_round (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             in_valid,
    input  des_pkg::block_t  in_lr,
    input  des_pkg::subkey_t round_key,
    output logic             out_valid,
    output des_pkg::block_t  out_lr
);
    logic            valid_reg;
    des_pkg::block_t lr_reg;
    des_pkg::block_t lr_next;

    assign lr_next = {in_lr[31:0], in_lr[63:32] ^ des_pkg::feistel(in_lr[31:0], round_key)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            lr_reg <= lr_next;
    end

    assign out_valid = valid_reg;
    assign out_lr    = lr_reg;
endmodule

// File: hw/rtl/des_block_cipher.sv
// DES block cipher, one 64-bit block per transfer.
// Channel in_blk carries blocks in, out_blk carries results out; both use a
// valid/ready handshake and a transfer takes place when both are high.
// Channel cfg writes register 0 (64-bit key) or register 1 (decrypt flag);
// it is always ready. Write configuration only while no block is in flight.
// The datapath has one register stage per Feistel round, with the initial
// permutation ahead of the first round and the final permutation on the
// output of the last; a block passes through all sixteen stages in turn.
// Throughput is one block per cycle while out_blk is not stalled.
// When the receiver stalls with a result waiting in the last stage, the whole
// pipeline holds and in_blk.ready drops; bubbles inside it are not squeezed
// out while it holds. If the last stage is empty the pipeline keeps moving.
// Reset clears the key, the mode and all stage valid flags.
module des_block_cipher (
    input logic     clk,
    input logic     rst_n,
    des_stream_if.sink   in_blk,
    des_stream_if.source out_blk,
    des_cfg_if.sink      cfg
);
    des_pkg::subkey_t round_key [des_pkg::Rounds];
    logic             stage_valid [des_pkg::Rounds+1];
    des_pkg::block_t  stage_lr    [des_pkg::Rounds+1];
    logic             advance;

    des_keysched u_keys (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .round_key (round_key)
    );

    // The pipeline moves when the last stage is empty or being taken.
    assign advance = out_blk.ready || !stage_valid[des_pkg::Rounds];
    assign in_blk.ready = advance;

    assign stage_valid[0] = in_blk.valid;
    assign stage_lr[0]    = des_pkg::perm_ip(in_blk.data);

    for (genvar g = 0; g < des_pkg::Rounds; g++)
    begin : g_round
        des_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (stage_valid[g]),
            .in_lr     (stage_lr[g]),
            .round_key (round_key[g]),
            .out_valid (stage_valid[g+1]),
            .out_lr    (stage_lr[g+1])
        );
    end

    assign out_blk.valid = stage_valid[des_pkg::Rounds];
    assign out_blk.data  = des_pkg::perm_fp({stage_lr[des_pkg::Rounds][31:0],
                                             stage_lr[des_pkg::Rounds][63:32]});
endmodule
